// File: design/pcap_tfc_pkg.sv
// shared constants, types and helper functions for the pcap tcp flag counter
package pcap_tfc_pkg;

  // counter width; the reported totals are the low 32 bits
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned FIELD_W     = 32;

  // capture layout
  localparam int unsigned GLOBAL_LEN   = 24;
  localparam int unsigned LINKTYPE_POS = 20;
  localparam int unsigned RHDR_LEN     = 16;
  localparam int unsigned CAPLEN_POS   = 8;
  localparam int unsigned CAPLEN_END   = 12;
  localparam int unsigned LINK_LEN     = 4;
  localparam int unsigned VERSION_POS  = 4;
  localparam int unsigned PROTO_POS    = 13;
  localparam int unsigned FLAGS_POS    = 37;
  localparam int unsigned MIN_BODY     = 38;

  // expected header values
  localparam int unsigned LINK_LOOPBACK = 2;
  localparam int unsigned PROTO_TCP     = 6;
  localparam int unsigned IP_V4         = 4;

  // tcp flag bits
  localparam int unsigned FLAG_SYN = 1;
  localparam int unsigned FLAG_ACK = 4;

  localparam int unsigned TDATA_W = 136;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [FIELD_W-1:0]     field_t;

  typedef enum logic [1:0] {
    CLS_SYN_ACK = 2'd0,
    CLS_SYN     = 2'd1,
    CLS_ACK     = 2'd2,
    CLS_NONE    = 2'd3
  } class_e;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_LINKTYPE  = 3'd1,
    ERR_LINK_WORD = 3'd2,
    ERR_PROTOCOL  = 3'd3,
    ERR_VERSION   = 3'd4,
    ERR_SHORT     = 3'd5
  } err_e;

  typedef struct packed {
    class_e record_class;
    err_e   error_code;
    field_t syn_total;
    field_t syn_ack_total;
    field_t ack_total;
    field_t record_number;
  } res_t;

  function automatic count_t sat_inc(count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  function automatic field_t to_field(count_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[FIELD_W-1:0];
  endfunction

endpackage

// File: design/pcap_tfc_parser.sv
// byte parser: header offsets, field capture, classification and counters
module pcap_tfc_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [7:0]         data_i,
  input  logic               sof_i,
  output logic               res_valid_o,
  output pcap_tfc_pkg::res_t res_o
);
  import pcap_tfc_pkg::*;

  logic [4:0]  g_off_q, g_off_c, g_off_d;
  logic        lt_nz_q, lt_nz_c, lt_nz_d;
  logic        in_body_q, in_body_c, in_body_d;
  logic [31:0] roff_q, roff_c, roff_d, roff_inc;
  logic [31:0] cap_q, cap_c, cap_d;
  logic [31:0] link_q, link_c, link_d;
  logic [3:0]  ver_q, ver_c, ver_d;
  logic [7:0]  proto_q, proto_c, proto_d;
  logic [7:0]  flags_q, flags_c, flags_d;
  count_t      syn_q, syn_c, syn_d;
  count_t      sack_q, sack_c, sack_d;
  count_t      ack_q, ack_c, ack_d;
  count_t      rec_q, rec_c, rec_d;
  logic        finish;
  class_e      cls;
  err_e        err;

  // start of file clears everything before the byte is used
  always_comb begin
    g_off_c   = sof_i ? '0 : g_off_q;
    lt_nz_c   = sof_i ? 1'b0 : lt_nz_q;
    in_body_c = sof_i ? 1'b0 : in_body_q;
    roff_c    = sof_i ? '0 : roff_q;
    cap_c     = sof_i ? '0 : cap_q;
    link_c    = sof_i ? '0 : link_q;
    ver_c     = sof_i ? '0 : ver_q;
    proto_c   = sof_i ? '0 : proto_q;
    flags_c   = sof_i ? '0 : flags_q;
    syn_c     = sof_i ? '0 : syn_q;
    sack_c    = sof_i ? '0 : sack_q;
    ack_c     = sof_i ? '0 : ack_q;
    rec_c     = sof_i ? '0 : rec_q;
  end

  always_comb begin
    g_off_d   = g_off_c;
    lt_nz_d   = lt_nz_c;
    in_body_d = in_body_c;
    roff_d    = roff_c;
    cap_d     = cap_c;
    link_d    = link_c;
    ver_d     = ver_c;
    proto_d   = proto_c;
    flags_d   = flags_c;
    syn_d     = syn_c;
    sack_d    = sack_c;
    ack_d     = ack_c;
    rec_d     = rec_c;
    roff_inc  = roff_c + 32'd1;
    finish    = 1'b0;

    if (g_off_c < 5'(GLOBAL_LEN)) begin
      if (g_off_c >= 5'(LINKTYPE_POS)) begin
        lt_nz_d = lt_nz_c | (data_i != 8'd0);
      end
      g_off_d = g_off_c + 5'd1;
    end else if (!in_body_c) begin
      if (roff_c == '0) begin
        cap_d   = '0;
        link_d  = '0;
        ver_d   = '0;
        proto_d = '0;
        flags_d = '0;
      end
      if (roff_c >= 32'(CAPLEN_POS) && roff_c < 32'(CAPLEN_END)) begin
        cap_d = cap_d | (32'(data_i) << {roff_c[1:0], 3'b000});
      end
      if (roff_inc >= 32'(RHDR_LEN)) begin
        roff_d = '0;
        if (cap_d == '0) begin
          finish = 1'b1;
        end else begin
          in_body_d = 1'b1;
        end
      end else begin
        roff_d = roff_inc;
      end
    end else begin
      if (roff_c < 32'(LINK_LEN)) begin
        link_d = link_c | (32'(data_i) << {roff_c[1:0], 3'b000});
      end else if (roff_c == 32'(VERSION_POS)) begin
        ver_d = data_i[7:4];
      end else if (roff_c == 32'(PROTO_POS)) begin
        proto_d = data_i;
      end else if (roff_c == 32'(FLAGS_POS)) begin
        flags_d = data_i;
      end
      if (roff_inc >= cap_c) begin
        finish = 1'b1;
      end else begin
        roff_d = roff_inc;
      end
    end

    // classification from the flags seen so far
    if (flags_d[FLAG_SYN] && flags_d[FLAG_ACK]) begin
      cls = CLS_SYN_ACK;
    end else if (flags_d[FLAG_SYN]) begin
      cls = CLS_SYN;
    end else if (flags_d[FLAG_ACK]) begin
      cls = CLS_ACK;
    end else begin
      cls = CLS_NONE;
    end

    if (lt_nz_d) begin
      err = ERR_LINKTYPE;
    end else if (cap_d < 32'(MIN_BODY)) begin
      err = ERR_SHORT;
    end else if (link_d != 32'(LINK_LOOPBACK)) begin
      err = ERR_LINK_WORD;
    end else if (proto_d != 8'(PROTO_TCP)) begin
      err = ERR_PROTOCOL;
    end else if (ver_d != 4'(IP_V4)) begin
      err = ERR_VERSION;
    end else begin
      err = ERR_OK;
    end

    if (finish) begin
      if (err == ERR_OK) begin
        case (cls)
          CLS_SYN_ACK: sack_d = sat_inc(sack_c);
          CLS_SYN:     syn_d  = sat_inc(syn_c);
          CLS_ACK:     ack_d  = sat_inc(ack_c);
          default:     ;
        endcase
      end
      rec_d     = sat_inc(rec_c);
      in_body_d = 1'b0;
      roff_d    = '0;
    end
  end

  assign res_valid_o          = valid_i && finish;
  assign res_o.record_class   = cls;
  assign res_o.error_code     = err;
  assign res_o.syn_total      = to_field(syn_d);
  assign res_o.syn_ack_total  = to_field(sack_d);
  assign res_o.ack_total      = to_field(ack_d);
  assign res_o.record_number  = to_field(rec_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_off_q   <= '0;
      lt_nz_q   <= 1'b0;
      in_body_q <= 1'b0;
      roff_q    <= '0;
      cap_q     <= '0;
      link_q    <= '0;
      ver_q     <= '0;
      proto_q   <= '0;
      flags_q   <= '0;
      syn_q     <= '0;
      sack_q    <= '0;
      ack_q     <= '0;
      rec_q     <= '0;
    end else if (valid_i) begin
      g_off_q   <= g_off_d;
      lt_nz_q   <= lt_nz_d;
      in_body_q <= in_body_d;
      roff_q    <= roff_d;
      cap_q     <= cap_d;
      link_q    <= link_d;
      ver_q     <= ver_d;
      proto_q   <= proto_d;
      flags_q   <= flags_d;
      syn_q     <= syn_d;
      sack_q    <= sack_d;
      ack_q     <= ack_d;
      rec_q     <= rec_d;
    end
  end

`ifndef SYNTH
  a_goff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_off_q <= 5'(GLOBAL_LEN))
    else $error("global offset past header length");
  a_body_after_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_body_q |-> (g_off_q == 5'(GLOBAL_LEN)))
    else $error("record body before global header done");
  a_body_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_body_q |-> (roff_q < cap_q))
    else $error("body offset past captured length");
  a_hdr_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_body_q |-> (roff_q < 32'(RHDR_LEN)))
    else $error("record header offset out of range");
`endif

endmodule

// File: design/pcap_tfc_out_stage.sv
// result register with one skid entry
module pcap_tfc_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pcap_tfc_pkg::res_t data_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               ready_i,
  output pcap_tfc_pkg::res_t data_o
);
  import pcap_tfc_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_data_q, out_data_d;
  res_t skid_data_q, skid_data_d;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (push_i && !skid_valid_q) begin
      if (!out_valid_q || ready_i) begin
        out_valid_d = 1'b1;
        out_data_d  = data_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = data_i;
      end
    end else if (out_valid_q && ready_i) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without output entry");
  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !ready_i && push_i))
    else $error("skid filled without a stalled output");
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && ready_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid entry not moved to output");
`endif

endmodule

// File: design/pcap_tcp_flag_counter_core.sv
// top level of the pcap tcp flag counter
//
// takes a little-endian pcap capture one byte per word on the slave stream:
//   s_axis_tdata_i holds the byte, s_axis_tuser_i marks the first byte of a
//   capture and clears the parser and all counters before that byte is used
// after the 24-byte global header (link type must be 0) each record gives one
// result word on the master stream when its last byte is taken: tcp class,
// error code, the three saturating totals and the record index
// records with a nonzero error code are reported but not counted
//
// throughput: one byte per cycle while s_axis_tready_o is high; every byte is
// parsed in the cycle it is accepted, using 32-bit compares and increments
// each result word is registered, in the skid entry if the output is stalled
//
// reset leaves the parser waiting for a global header with all counters zero
// a result register plus one skid entry sit on the output, so bytes keep
// flowing while a result waits; s_axis_tready_o drops only while both entries
// are held by a stalled receiver, and rises again as soon as one is taken
// a record cut short by a new start of capture gives no result
module pcap_tcp_flag_counter_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic         s_axis_tuser_i,   // [0] start_of_file
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [1:0] record_class, [4:2] error_code, [36:5] syn_total,
  // [68:37] syn_ack_total, [100:69] ack_total, [132:101] record_number,
  // [135:133] zero
  output logic [pcap_tfc_pkg::TDATA_W-1:0] m_axis_tdata_o
);
  import pcap_tfc_pkg::*;

  logic in_accept;
  logic res_valid;
  res_t res;
  res_t out_res;
  logic stage_ready;

  assign in_accept       = s_axis_tvalid_i && stage_ready;
  assign s_axis_tready_o = stage_ready;

  // per-byte parsing and counting
  pcap_tfc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_accept),
    .data_i      (s_axis_tdata_i),
    .sof_i       (s_axis_tuser_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register and skid entry
  pcap_tfc_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .ready_o (stage_ready),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_res)
  );

  // fields packed from the low bit up
  assign m_axis_tdata_o = {3'b000,
                           out_res.record_number,
                           out_res.ack_total,
                           out_res.syn_ack_total,
                           out_res.syn_total,
                           out_res.error_code,
                           out_res.record_class};

endmodule

// File: tb/pcap_tcp_flag_counter_core_tb.sv
// testbench for the pcap tcp flag counter: byte stream stimulus with a running capture parser
`timescale 1ns / 1ps

module pcap_tcp_flag_counter_core_tb;
  import pcap_tfc_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 5000;  // cycles with no word taken on either side
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct {
    class_e      cls;
    err_e        err;
    logic [31:0] syn_n;
    logic [31:0] syn_ack_n;
    logic [31:0] ack_n;
    logic [31:0] rec_n;
  } flag_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic         s_tvalid = 1'b0;
  logic [7:0]   s_tdata  = 8'h00;
  logic         s_tuser  = 1'b0;
  logic         m_tready = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [TDATA_W-1:0] m_axis_tdata_o;

  always #5 clk_i = ~clk_i;

  pcap_tcp_flag_counter_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),   // [7:0] data_byte
    .s_axis_tuser_i  (s_tuser),   // [0] start_of_file
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // running copy of the parser state
  int unsigned hdr_pos;
  logic [31:0] cap_linktype;
  logic [31:0] rec_pos;
  logic [31:0] rec_len;
  logic [31:0] loop_word;
  logic [3:0]  ip_ver;
  logic [7:0]  ip_proto;
  logic [7:0]  tcp_flg;
  logic [31:0] cnt_syn;
  logic [31:0] cnt_syn_ack;
  logic [31:0] cnt_ack;
  logic [31:0] rec_idx;
  bit          body_phase;

  flag_result_t pending_results[$];

  int unsigned mismatch_count = 0;
  int unsigned bytes_taken    = 0;
  int unsigned records_seen   = 0;
  int unsigned records_rejected = 0;
  int unsigned records_predicted = 0;
  int unsigned idle_cycles    = 0;

  // idling controls
  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_left   = 0;

  function automatic logic [31:0] bump_sat(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic void clear_capture();
    hdr_pos      = 0;
    cap_linktype = '0;
    rec_pos      = '0;
    rec_len      = '0;
    loop_word    = '0;
    ip_ver       = '0;
    ip_proto     = '0;
    tcp_flg      = '0;
    cnt_syn      = '0;
    cnt_syn_ack  = '0;
    cnt_ack      = '0;
    rec_idx      = '0;
    body_phase   = 1'b0;
  endfunction

  // classify the record just ended and queue what the block should report
  function automatic void close_record();
    flag_result_t r;
    bit has_syn;
    bit has_ack;
    has_syn = tcp_flg[FLAG_SYN];
    has_ack = tcp_flg[FLAG_ACK];
    if (has_syn && has_ack) r.cls = CLS_SYN_ACK;
    else if (has_syn)       r.cls = CLS_SYN;
    else if (has_ack)       r.cls = CLS_ACK;
    else                    r.cls = CLS_NONE;

    // error priority: link type, too short, link word, protocol, version
    if (cap_linktype != 0)               r.err = ERR_LINKTYPE;
    else if (rec_len < MIN_BODY)         r.err = ERR_SHORT;
    else if (loop_word != LINK_LOOPBACK) r.err = ERR_LINK_WORD;
    else if (ip_proto != 8'(PROTO_TCP))  r.err = ERR_PROTOCOL;
    else if (ip_ver != 4'(IP_V4))        r.err = ERR_VERSION;
    else                                 r.err = ERR_OK;

    if (r.err == ERR_OK) begin
      case (r.cls)
        CLS_SYN_ACK: cnt_syn_ack = bump_sat(cnt_syn_ack);
        CLS_SYN:     cnt_syn     = bump_sat(cnt_syn);
        CLS_ACK:     cnt_ack     = bump_sat(cnt_ack);
        default: ;
      endcase
    end
    r.syn_n     = cnt_syn;
    r.syn_ack_n = cnt_syn_ack;
    r.ack_n     = cnt_ack;
    r.rec_n     = rec_idx;
    pending_results.push_back(r);
    records_predicted++;
    rec_idx    = bump_sat(rec_idx);
    body_phase = 1'b0;
    rec_pos    = '0;
  endfunction

  // advance the parser by one accepted byte
  function automatic void track_capture_byte(logic [7:0] b, logic sof);
    if (sof) clear_capture();
    if (hdr_pos < GLOBAL_LEN) begin
      if (hdr_pos >= LINKTYPE_POS) cap_linktype[8*(hdr_pos-LINKTYPE_POS) +: 8] = b;
      hdr_pos++;
    end else if (!body_phase) begin
      if (rec_pos == 0) begin
        rec_len   = '0;
        loop_word = '0;
        ip_ver    = '0;
        ip_proto  = '0;
        tcp_flg   = '0;
      end
      if (rec_pos >= CAPLEN_POS && rec_pos < CAPLEN_END)
        rec_len[8*(rec_pos-CAPLEN_POS) +: 8] = b;
      rec_pos++;
      if (rec_pos >= RHDR_LEN) begin
        rec_pos = '0;
        // empty body ends the record on its last header byte
        if (rec_len == 0) close_record();
        else body_phase = 1'b1;
      end
    end else begin
      if (rec_pos < LINK_LEN)        loop_word[8*rec_pos +: 8] = b;
      else if (rec_pos == VERSION_POS) ip_ver = b[7:4];
      else if (rec_pos == PROTO_POS)   ip_proto = b;
      else if (rec_pos == FLAGS_POS)   tcp_flg = b;
      rec_pos++;
      if (rec_pos >= rec_len) close_record();
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // monitor: predicts on every byte taken, checks every result word taken
  always @(posedge clk_i) begin
    flag_result_t r;
    if (rst_ni) begin
      idle_cycles++;
      if (s_tvalid && s_axis_tready_o) begin
        track_capture_byte(s_tdata, s_tuser);
        bytes_taken++;
        idle_cycles = 0;
      end
      if (m_axis_tvalid_o && m_tready) begin
        idle_cycles = 0;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual %h", $time,
                   m_axis_tdata_o);
          mismatch_count++;
        end else begin
          r = pending_results.pop_front();
          records_seen++;
          if (r.err != ERR_OK) records_rejected++;
          check_field("record_class",  32'(r.cls),  32'(m_axis_tdata_o[1:0]));
          check_field("error_code",    32'(r.err),  32'(m_axis_tdata_o[4:2]));
          check_field("syn_total",     r.syn_n,     m_axis_tdata_o[36:5]);
          check_field("syn_ack_total", r.syn_ack_n, m_axis_tdata_o[68:37]);
          check_field("ack_total",     r.ack_n,     m_axis_tdata_o[100:69]);
          check_field("record_number", r.rec_n,     m_axis_tdata_o[132:101]);
        end
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, nothing taken for %0d cycles", $time, IDLE_LIMIT);
        $display("pcap_tcp_flag_counter_core_tb: done, errors");
        $finish;
      end
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // receiver: long hold-off on request, otherwise random stalls
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_request > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_request - 1;
      hold_request = 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (sink_idle_en && $urandom_range(0, 99) < 25) begin
      m_tready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      m_tready <= 1'b1;
    end
  end

  // offer one byte and wait until it is taken
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= sof;
    do @(posedge clk_i); while (!s_axis_tready_o);
    gap = src_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tuser  <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // 24-byte global header; keep < 0 sends it whole
  task automatic send_capture_hdr(input logic [31:0] ltype, input logic sof, input int keep);
    logic [7:0] b;
    for (int pos = 0; pos < GLOBAL_LEN; pos++) begin
      if (keep >= 0 && pos >= keep) return;
      b = 8'($urandom_range(0, 255));
      if (pos >= LINKTYPE_POS) b = ltype[8*(pos-LINKTYPE_POS) +: 8];
      send_byte(b, sof && pos == 0);
    end
  endtask

  // record header plus body with the checked fields placed; keep < 0 sends it whole
  task automatic send_record(input logic [31:0] len, input logic [31:0] lword,
                             input logic [3:0] ver, input logic [7:0] proto,
                             input logic [7:0] flg, input int keep);
    logic [7:0] b;
    int n;
    n = 0;
    for (int pos = 0; pos < RHDR_LEN; pos++) begin
      if (keep >= 0 && n >= keep) return;
      b = 8'($urandom_range(0, 255));
      if (pos >= CAPLEN_POS && pos < CAPLEN_END) b = len[8*(pos-CAPLEN_POS) +: 8];
      send_byte(b, 1'b0);
      n++;
    end
    for (int pos = 0; pos < int'(len); pos++) begin
      if (keep >= 0 && n >= keep) return;
      b = 8'($urandom_range(0, 255));
      if (pos < LINK_LEN)          b = lword[8*pos +: 8];
      else if (pos == VERSION_POS) b[7:4] = ver;
      else if (pos == PROTO_POS)   b = proto;
      else if (pos == FLAGS_POS)   b = flg;
      send_byte(b, 1'b0);
      n++;
    end
  endtask

  task automatic send_good(input logic [7:0] flg);
    send_record(MIN_BODY + $urandom_range(0, 4), LINK_LOOPBACK, 4'(IP_V4), 8'(PROTO_TCP),
                flg, -1);
  endtask

  // random flags biased toward the four classes
  function automatic logic [7:0] pick_flags();
    logic [7:0] mask;
    logic [7:0] f;
    mask = (8'd1 << FLAG_SYN) | (8'd1 << FLAG_ACK);
    f = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) != 0) begin
      f = f & ~mask;
      case ($urandom_range(0, 3))
        0: f = f | mask;
        1: f = f | (8'd1 << FLAG_SYN);
        2: f = f | (8'd1 << FLAG_ACK);
        default: ;
      endcase
    end
    return f;
  endfunction

  // parser must already wait for a global header after reset
  task automatic test_no_start_mark();
    send_capture_hdr(32'd0, 1'b0, -1);
    send_good(8'h02);
    send_good(8'h12);
  endtask

  task automatic test_classes();
    send_capture_hdr(32'd0, 1'b1, -1);
    send_good(8'h12);
    send_good(8'h02);
    send_good(8'h10);
    send_good(8'h00);
    send_good(8'hFF);
    send_good(8'hED);  // every bit but syn and ack
    send_record(MIN_BODY, LINK_LOOPBACK, 4'(IP_V4), 8'(PROTO_TCP), 8'h12, -1);
  endtask

  task automatic test_errors();
    send_capture_hdr(32'd0, 1'b1, -1);
    send_record(40, 32'd3, 4'(IP_V4), 8'(PROTO_TCP), 8'h02, -1);
    send_record(40, 32'hFFFF_FFFF, 4'(IP_V4), 8'(PROTO_TCP), 8'h02, -1);
    send_record(40, LINK_LOOPBACK, 4'(IP_V4), 8'd17, 8'h12, -1);
    send_record(40, LINK_LOOPBACK, 4'd6, 8'(PROTO_TCP), 8'h10, -1);
    // protocol wins over version
    send_record(40, LINK_LOOPBACK, 4'hF, 8'hFF, 8'h02, -1);
    // flags byte missing, and empty body
    send_record(MIN_BODY - 1, LINK_LOOPBACK, 4'(IP_V4), 8'(PROTO_TCP), 8'h12, -1);
    send_record(0, LINK_LOOPBACK, 4'(IP_V4), 8'(PROTO_TCP), 8'h12, -1);
    send_record(1, LINK_LOOPBACK, 4'(IP_V4), 8'(PROTO_TCP), 8'h12, -1);
    send_good(8'h02);
    // bad capture link type: every record rejected, still indexed
    send_capture_hdr(32'hFFFF_FFFF, 1'b1, -1);
    send_good(8'h12);
    send_record(0, LINK_LOOPBACK, 4'(IP_V4), 8'(PROTO_TCP), 8'h00, -1);
    send_capture_hdr(32'd1, 1'b1, -1);
    send_record(20, 32'd0, 4'(IP_V4), 8'(PROTO_TCP), 8'h00, -1);
  endtask

  // new start of capture cuts a record or a global header short
  task automatic test_truncation();
    send_capture_hdr(32'd0, 1'b1, -1);
    send_good(8'h10);
    send_record(44, LINK_LOOPBACK, 4'(IP_V4), 8'(PROTO_TCP), 8'h12, 30);
    send_capture_hdr(32'd0, 1'b1, -1);
    send_record(40, LINK_LOOPBACK, 4'(IP_V4), 8'(PROTO_TCP), 8'h02, 7);
    send_capture_hdr(32'hFF00_0000, 1'b1, 22);
    send_capture_hdr(32'd0, 1'b1, -1);
    send_good(8'h12);
  endtask

  // receiver holds off while short records keep coming, so the input stalls
  task automatic test_backpressure();
    src_idle_en = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (8) send_record(0, 32'd0, 4'd0, 8'd0, 8'd0, -1);
    send_good(8'h02);
    src_idle_en = 1'b1;
  endtask

  task automatic test_random();
    int unsigned bytes_start;
    int unsigned rec_start;
    logic [31:0] len;
    logic [31:0] lword;
    logic [3:0]  ver;
    logic [7:0]  proto;
    int unsigned r;
    int keep;
    bytes_start = bytes_taken;
    rec_start   = records_predicted;
    send_capture_hdr(32'd0, 1'b1, -1);
    while (bytes_taken - bytes_start < 150 || records_predicted - rec_start < 3) begin
      // stretches with and without idling
      if ($urandom_range(0, 9) == 0) src_idle_en  = ~src_idle_en;
      if ($urandom_range(0, 9) == 0) sink_idle_en = ~sink_idle_en;
      r = $urandom_range(0, 99);
      if (r < 10)      len = 0;
      else if (r < 25) len = $urandom_range(1, MIN_BODY - 1);
      else if (r < 92) len = $urandom_range(MIN_BODY, 60);
      else             len = $urandom_range(61, 160);
      lword = ($urandom_range(0, 99) < 85) ? LINK_LOOPBACK : $urandom();
      ver   = 4'(($urandom_range(0, 99) < 85) ? IP_V4 : $urandom_range(0, 15));
      proto = 8'(($urandom_range(0, 99) < 85) ? PROTO_TCP : $urandom_range(0, 255));
      keep  = ($urandom_range(0, 99) < 4) ? int'($urandom_range(0, 16 + len)) : -1;
      send_record(len, lword, ver, proto, pick_flags(), keep);
      // truncated record or occasional fresh capture, sometimes with a bad link type
      if (keep >= 0 || $urandom_range(0, 99) < 5)
        send_capture_hdr(($urandom_range(0, 99) < 75) ? 32'd0 : $urandom(), 1'b1, -1);
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  initial begin
    clear_capture();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_start_mark();
    test_classes();
    test_errors();
    test_truncation();
    test_backpressure();
    test_random();

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("parsed %0d capture bytes, checked %0d record results (%0d rejected)",
             bytes_taken, records_seen, records_rejected);
    $display("covered all classes, all error codes, empty and cut records, output stall");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("pcap_tcp_flag_counter_core_tb: done, clean");
    end else begin
      $display("pcap_tcp_flag_counter_core_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
design/pcap_tfc_pkg.sv
design/pcap_tfc_parser.sv
design/pcap_tfc_out_stage.sv
design/pcap_tcp_flag_counter_core.sv
tb/pcap_tcp_flag_counter_core_tb.sv
